### sv/interval_booking_admission_assert.svh
// Assertion macros for the booking admission block.
`ifndef INTERVAL_BOOKING_ADMISSION_ASSERT_SVH
`define INTERVAL_BOOKING_ADMISSION_ASSERT_SVH
// Condition implies consequence in the same cycle.
`define IBA_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Condition implies consequence in the next cycle.
`define IBA_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

### sv/iba_pkg.sv
// ----------------------------------------------------------------------------
// iba_pkg
// Types and constants for the interval booking admission block.
// ----------------------------------------------------------------------------
package iba_pkg;
    localparam int MAX_POINTS_DEF = 256;
    localparam logic [7:0] MAX_OVERLAP_RST = 8'd2;
    localparam int TW = 32;
    localparam int DW = 10;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OVERLAP = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    typedef struct packed {
        logic [TW-1:0] start_time;
        logic [TW-1:0] end_time;
    } t_req;

    typedef struct packed {
        logic       accepted;
        logic [1:0] status;
    } t_rsp;
endpackage

### sv/interval_booking_admission.sv
// ----------------------------------------------------------------------------
// interval_booking_admission
// Admits interval bookings while overlap depth stays within max_overlap.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel i_req_valid / o_req_stall carries start_time, end_time.
//   Result channel o_rsp_valid / i_rsp_stall carries accepted, status.
//   One result per request. max_overlap is written through i_cfg_we/i_cfg_data
//   while the block is idle; the user must keep to this, the block has no check.
// Timing:
//   Points are held sorted in one memory (time and delta) with a registered
//   read. A request takes a scan pass (one entry a cycle) that finds both
//   insertion spots and checks the running sum with the new deltas folded
//   in, then, if accepted, a rewrite pass from the top entry down. A
//   rejected request skips the rewrite pass and an invalid one skips both
//   passes. The next request is taken no earlier than the cycle after the
//   result is taken. o_req_stall is high while busy or while a result waits.
// Reset:
//   Synchronous, active low: table empty, max_overlap = 2, no result.
//   No clearing pass. A stalled result holds until taken.
// ----------------------------------------------------------------------------
module interval_booking_admission #(
    parameter int MAX_POINTS = iba_pkg::MAX_POINTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_stall,
    input  iba_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_stall,
    output iba_pkg::t_rsp o_rsp,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_data
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int TW = iba_pkg::TW;
    localparam int DW = iba_pkg::DW;
    localparam int SW = DW + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_SHFT = 3'd3;
    localparam logic [2:0] S_RSP  = 3'd4;

    logic [TW+DW-1:0] mem [MAX_POINTS];
    logic [TW+DW-1:0] r_rd;

    logic [2:0]  r_st, n_st;
    logic [7:0]  r_max;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [TW-1:0] r_s, r_e;
    logic [CW:0]   r_ra, n_ra;
    logic          r_rv, n_rv;
    logic [CW-1:0] r_ri, n_ri;
    logic [CW-1:0] r_ps, n_ps, r_pe, n_pe;
    logic          r_fs, n_fs, r_fe, n_fe;
    logic          r_ns, n_ns, r_ne, n_ne;
    logic signed [SW-1:0] r_sum, n_sum;
    logic          r_ov, n_ov;
    logic [CW:0]   r_wi, n_wi;
    logic          r_we, n_we;
    logic [AW-1:0] r_wa, n_wa;
    logic [TW+DW-1:0] r_wd, n_wd;
    logic          r_ovld, n_ovld;
    iba_pkg::t_rsp r_rsp, n_rsp;
    logic [CW-1:0] r_ncnt, n_ncnt;

    logic [TW-1:0] rt;
    logic signed [DW-1:0] rdl;
    logic signed [SW-1:0] dsum;
    logic signed [SW-1:0] lim;
    logic [CW:0] wnext;
    logic [1:0]  nnew;

    assign rt    = r_rd[TW+DW-1:DW];
    assign rdl   = signed'(r_rd[DW-1:0]);
    assign lim   = $signed({{(SW-8){1'b0}}, r_max});
    assign wnext = r_wi - 1'b1;

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            mem[r_wa] <= r_wd;
        end
        r_rd <= mem[n_ra[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_max  <= iba_pkg::MAX_OVERLAP_RST;
            r_cnt  <= '0;
            r_ovld <= 1'b0;
            r_rv   <= 1'b0;
            r_we   <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_cnt  <= n_cnt;
            r_ovld <= n_ovld;
            r_rv   <= n_rv;
            r_we   <= n_we;
            if (i_cfg_we) begin
                r_max <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE && i_req_valid && !o_req_stall) begin
            r_s <= i_req.start_time;
            r_e <= i_req.end_time;
        end
        r_ra <= n_ra; r_ri <= n_ri; r_ps <= n_ps; r_pe <= n_pe;
        r_fs <= n_fs; r_fe <= n_fe; r_ns <= n_ns; r_ne <= n_ne;
        r_sum <= n_sum; r_ov <= n_ov; r_wi <= n_wi;
        r_wa <= n_wa; r_wd <= n_wd; r_rsp <= n_rsp; r_ncnt <= n_ncnt;
    end

    assign o_req_stall = (r_st != S_IDLE) || r_ovld;
    assign o_rsp_valid = r_ovld;
    assign o_rsp       = r_rsp;

    // old index feeding new index w: w - (ns&&w>ps) - (ne&&w>pe+ns)
    function automatic logic [CW:0] shift_src(input logic [CW:0] w);
        logic [CW:0] shs;
        logic [CW:0] she;
        shs = (CW+1)'(r_ns && (w > {1'b0, r_ps}));
        she = (CW+1)'(r_ne && (w > ({1'b0, r_pe} + (CW+1)'(r_ns))));
        return w - shs - she;
    endfunction

    // existing entry with deltas merged at equal times
    function automatic logic [TW+DW-1:0] merge_word(input logic [TW+DW-1:0] v,
                                                    input logic [CW:0] src);
        logic signed [DW-1:0] d;
        d = signed'(v[DW-1:0]);
        if (!r_ns && src == {1'b0, r_ps}) d = d + DW'(1);
        if (!r_ne && src == {1'b0, r_pe}) d = d - DW'(1);
        return {v[TW+DW-1:DW], d};
    endfunction

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_ovld = r_ovld; n_rsp = r_rsp;
        n_ra = r_ra; n_rv = 1'b0; n_ri = r_ri; n_ps = r_ps; n_pe = r_pe;
        n_fs = r_fs; n_fe = r_fe; n_ns = r_ns; n_ne = r_ne;
        n_sum = r_sum; n_ov = r_ov; n_wi = r_wi;
        n_we = 1'b0; n_wa = r_wa; n_wd = r_wd; n_ncnt = r_ncnt;
        dsum = '0; nnew = '0;
        if (r_ovld && !i_rsp_stall) begin
            n_ovld = 1'b0;
        end
        case (r_st)
            S_IDLE: begin
                if (i_req_valid && !o_req_stall) begin
                    if (i_req.start_time >= i_req.end_time) begin
                        n_rsp  = '{accepted: 1'b0, status: iba_pkg::ST_INVALID};
                        n_st   = S_RSP;
                    end else begin
                        n_ra = '0; n_ri = '0;
                        n_rv = (r_cnt != '0);
                        n_fs = 1'b0; n_fe = 1'b0; n_ns = 1'b0; n_ne = 1'b0;
                        n_sum = '0; n_ov = 1'b0;
                        n_st = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // r_rd holds entry r_ri when r_rv; fold new points in order
                if (r_rv) begin
                    n_rv = ({1'b0, r_ri} + 1'b1) < {1'b0, r_cnt};
                    n_ra = r_ra + 1'b1;
                    n_ri = r_ri + 1'b1;
                    dsum = SW'(rdl);
                    if (!r_fs && rt >= r_s) begin
                        n_fs = 1'b1; n_ps = r_ri; n_ns = (rt != r_s);
                        dsum = dsum + SW'(1);
                    end
                    if (!r_fe && rt >= r_e) begin
                        n_fe = 1'b1; n_pe = r_ri; n_ne = (rt != r_e);
                        dsum = dsum - SW'(1);
                    end
                    // a new start point sits before this entry: its +1 counts alone
                    if (!r_fs && rt > r_s && r_sum + SW'(1) > lim) begin
                        n_ov = 1'b1;
                    end
                    if (r_sum + dsum > lim) begin
                        n_ov = 1'b1;
                    end
                    n_sum = r_sum + dsum;
                end else begin
                    if (!r_fs) begin
                        n_fs = 1'b1; n_ps = r_cnt; n_ns = 1'b1;
                        if (r_sum + SW'(1) > lim) n_ov = 1'b1;
                    end
                    if (!r_fe) begin
                        n_fe = 1'b1; n_pe = r_cnt; n_ne = 1'b1;
                    end
                    n_st = S_DEC;
                end
            end
            S_DEC: begin
                nnew = {1'b0, r_ns} + {1'b0, r_ne};
                if ({1'b0, r_cnt} + (CW+1)'(nnew) > (CW+1)'(MAX_POINTS)) begin
                    n_rsp = '{accepted: 1'b0, status: iba_pkg::ST_FULL};
                    n_st  = S_RSP;
                end else if (r_ov) begin
                    n_rsp = '{accepted: 1'b0, status: iba_pkg::ST_OVERLAP};
                    n_st  = S_RSP;
                end else begin
                    n_rsp  = '{accepted: 1'b1, status: iba_pkg::ST_OK};
                    n_ncnt = CW'({1'b0, r_cnt} + (CW+1)'(nnew));
                    // walk destination index from top down
                    n_wi = {1'b0, n_ncnt} - 1'b1;
                    n_ra = shift_src(n_wi);
                    n_rv = 1'b1;
                    n_st = S_SHFT;
                end
            end
            S_SHFT: begin
                // dest r_wi; r_rd holds its source entry read last cycle
                if (r_rv) begin
                    n_we = 1'b1; n_wa = r_wi[AW-1:0];
                    if (r_ne && r_wi == {1'b0, r_pe} + (CW+1)'(r_ns)) begin
                        n_wd = {r_e, DW'(-1)};
                    end else if (r_ns && r_wi == {1'b0, r_ps}) begin
                        n_wd = {r_s, DW'(1)};
                    end else begin
                        n_wd = merge_word(r_rd, shift_src(r_wi));
                    end
                    if (r_wi == '0) begin
                        n_cnt = r_ncnt;
                        n_st  = S_RSP;
                    end else begin
                        n_wi = wnext;
                        n_ra = shift_src(wnext);
                        n_rv = 1'b1;
                    end
                end
            end
            S_RSP: begin
                if (!r_ovld) begin
                    n_ovld = 1'b1;
                    n_st   = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    `include "interval_booking_admission_assert.svh"
    `IBA_ASSERT_IMP(a_rsp_hold, i_clk, i_rst_n, o_rsp_valid, o_req_stall, "req with rsp pending")
    `IBA_ASSERT_NEXT(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(MAX_POINTS), "count over cap")
    `IBA_ASSERT_IMP(a_we_busy, i_clk, i_rst_n, r_we, r_st == S_SHFT || r_st == S_RSP, "stray write")
endmodule

### dv/interval_booking_admission_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_booking_admission_checker
// Watches the request, result and register ports of the booking admission
// block. Keeps its own sorted table of time points, predicts the result of
// every request taken and compares it with the returned result.
// ----------------------------------------------------------------------------
module interval_booking_admission_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic          i_req_stall,
    input  iba_pkg::t_req i_req,
    input  logic          i_rsp_valid,
    input  logic          i_rsp_stall,
    input  iba_pkg::t_rsp i_rsp,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_data,
    output int            o_pending,
    output int            o_fail_count
);
    logic [iba_pkg::TW-1:0] point_times[$];
    int                     point_deltas[$];
    logic [7:0]             overlap_limit = iba_pkg::MAX_OVERLAP_RST;
    iba_pkg::t_rsp          rsp_expected[$];
    int                     fail_count = 0;
    int                     pend_count = 0;

    assign o_pending    = pend_count;
    assign o_fail_count = fail_count;

    function automatic void add_point(ref logic [iba_pkg::TW-1:0] times[$],
                                      ref int deltas[$],
                                      input logic [iba_pkg::TW-1:0] t, input int d);
        int pos;
        pos = 0;
        while (pos < times.size() && times[pos] < t) pos++;
        if (pos < times.size() && times[pos] == t) begin
            deltas[pos] += d;
        end else begin
            times.insert(pos, t);
            deltas.insert(pos, d);
        end
    endfunction

    function automatic iba_pkg::t_rsp admit_booking(input logic [iba_pkg::TW-1:0] s,
                                                    input logic [iba_pkg::TW-1:0] e);
        logic [iba_pkg::TW-1:0] times[$];
        int                     deltas[$];
        int                     depth;
        iba_pkg::t_rsp          r;
        r.status = iba_pkg::ST_OK;
        if (s >= e) begin
            r.status = iba_pkg::ST_INVALID;
        end else begin
            times  = point_times;
            deltas = point_deltas;
            add_point(times, deltas, s, 1);
            add_point(times, deltas, e, -1);
            if (times.size() > iba_pkg::MAX_POINTS_DEF) begin
                r.status = iba_pkg::ST_FULL;
            end else begin
                depth = 0;
                foreach (deltas[i]) begin
                    depth += deltas[i];
                    if (depth > int'(overlap_limit)) begin
                        r.status = iba_pkg::ST_OVERLAP;
                        break;
                    end
                end
                if (r.status == iba_pkg::ST_OK) begin
                    point_times  = times;
                    point_deltas = deltas;
                end
            end
        end
        r.accepted = (r.status == iba_pkg::ST_OK);
        return r;
    endfunction

    always @(posedge i_clk) begin
        iba_pkg::t_rsp want;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                overlap_limit = i_cfg_data;
            end
            if (i_req_valid && !i_req_stall) begin
                rsp_expected = {rsp_expected,
                                admit_booking(i_req.start_time, i_req.end_time)};
            end
            if (i_rsp_valid && !i_rsp_stall) begin
                if (rsp_expected.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: accepted %0d status %0d",
                                 i_rsp.accepted, i_rsp.status);
                end else begin
                    want = rsp_expected.pop_front();
                    if (i_rsp.accepted !== want.accepted || i_rsp.status !== want.status) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected accepted %0d status %0d, got %0d %0d",
                                     want.accepted, want.status, i_rsp.accepted, i_rsp.status);
                    end
                end
            end
        end
        pend_count = rsp_expected.size();
    end
endmodule

### dv/interval_booking_admission_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_booking_admission_test
// Drives booking requests and overlap limit writes into the admission block
// under random idling on both channels and gives the verdict from the
// checker's failure count. Covers invalid intervals, overlap rejects,
// shared endpoints, a zero limit and a full point table.
// ----------------------------------------------------------------------------
module interval_booking_admission_test;
    localparam int QUIET_LIMIT = 20000;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_stall;
    iba_pkg::t_req req = '0;
    logic          rsp_valid;
    logic          rsp_stall = 1'b0;
    iba_pkg::t_rsp rsp;
    logic          cfg_we = 1'b0;
    logic [7:0]    cfg_data = '0;
    int            snd_idle = 0;
    int            rcv_idle = 0;
    int            pending;
    int            fail_count;
    int            quiet_cycles = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    interval_booking_admission i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(req_valid), .o_req_stall(req_stall), .i_req(req),
        .o_rsp_valid(rsp_valid), .i_rsp_stall(rsp_stall), .o_rsp(rsp),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data)
    );

    interval_booking_admission_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(req_valid), .i_req_stall(req_stall), .i_req(req),
        .i_rsp_valid(rsp_valid), .i_rsp_stall(rsp_stall), .i_rsp(rsp),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .o_pending(pending), .o_fail_count(fail_count)
    );

    always @(posedge i_clk) begin
        rsp_stall <= ($urandom_range(99) < rcv_idle);
    end

    always @(posedge i_clk) begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic book(input logic [iba_pkg::TW-1:0] s, input logic [iba_pkg::TW-1:0] e);
        while ($urandom_range(99) < snd_idle) begin
            req_valid <= 1'b0;
            @(posedge i_clk);
        end
        req_valid <= 1'b1;
        req       <= '{start_time: s, end_time: e};
        do @(posedge i_clk); while (req_stall);
    endtask

    task automatic book_random(input bit wide);
        logic [iba_pkg::TW-1:0] s;
        logic [iba_pkg::TW-1:0] e;
        logic [iba_pkg::TW-1:0] t;
        if (wide) begin
            s = $urandom;
            e = $urandom;
            if (s > e && $urandom_range(99) < 85) begin
                t = s; s = e; e = t;
            end
        end else begin
            s = $urandom_range(31);
            e = $urandom_range(32);
        end
        book(s, e);
    endtask

    task automatic set_limit(input logic [7:0] v);
        req_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        snd_idle = 31;
        rcv_idle = 85;
        // reset limit of two
        book(10, 20);
        book(10, 20);
        book(15, 18);
        book(20, 30);
        book(5, 5);
        book(9, 3);
        book(0, 1);
        book(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        book(32'hFFFF_FFFF, 32'h0000_0000);
        book(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        book(0, 32'hFFFF_FFFF);
        repeat (160) book_random(1'b0);
        set_limit(8'd1);
        repeat (80) book_random(1'b0);

        snd_idle = 85;
        rcv_idle = 31;
        set_limit(8'd0);
        book(40, 41);
        book(3, 4);
        repeat (20) book_random(1'b0);
        set_limit(8'd255);
        repeat (170) book_random(1'b1);

        snd_idle = 0;
        rcv_idle = 0;
        set_limit(8'd3);
        repeat (200) book_random($urandom_range(1));

        req_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
